// ===== sv/rvq_pkg.sv =====
// Shared types, constants and step functions for the rotation vector to
// quaternion block. No dependencies; imported by every module of the block.
package rvq_pkg;

  localparam int CORDIC_STEPS_DEF = 24;

  localparam logic [30:0] THRESHOLD_RESET = 31'd268;

  // Angle constants in Q.28
  localparam logic signed [33:0] PI_Q28      = 34'sd843314857;
  localparam logic signed [33:0] HALF_PI_Q28 = 34'sd421657428;
  localparam logic signed [33:0] TWO_PI_Q28  = 34'sd1686629713;
  localparam logic [31:0]        TWO_PI_U    = 32'd1686629713;
  localparam logic [31:0]        FOUR_PI_U   = 32'd3373259426;

  localparam logic signed [35:0] GAIN_Q30 = 36'sd652032874;
  localparam logic signed [35:0] ONE_Q30  = 36'sd1073741824;
  localparam logic signed [35:0] MONE_Q30 = -36'sd1073741824;

  localparam logic [63:0] ROOT_BIAS = 64'd1 << 56;
  localparam logic [63:0] W_NUM     = 64'd1 << 58;
  localparam logic [30:0] SAT_MAG   = 31'd1073741824;

  typedef struct packed {
    logic [63:0] rem;
    logic [63:0] root;
  } sq_t;

  typedef struct packed {
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] vz;
    logic [31:0]        n;
    logic [31:0]        d;
    logic               small_br;
    logic               neg_cos;
    logic signed [35:0] x;
    logic signed [35:0] y;
    logic signed [35:0] z;
  } cd_t;

  typedef struct packed {
    logic [63:0] rem;
    logic [30:0] q;
    logic        over;
  } dv_t;

  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    mag32 = v[31] ? 32'(-v) : 32'(v);
  endfunction

  function automatic logic signed [35:0] atan_q30(input int k);
    case (k)
      0:       atan_q30 = 36'sd843314857;
      1:       atan_q30 = 36'sd497837829;
      2:       atan_q30 = 36'sd263043837;
      3:       atan_q30 = 36'sd133525159;
      4:       atan_q30 = 36'sd67021687;
      5:       atan_q30 = 36'sd33543516;
      6:       atan_q30 = 36'sd16775851;
      7:       atan_q30 = 36'sd8388437;
      8:       atan_q30 = 36'sd4194283;
      9:       atan_q30 = 36'sd2097151;
      default: atan_q30 = 36'(64'sd1 <<< (30 - k));
    endcase
  endfunction

  // One bit of the restoring square root
  function automatic sq_t isqrt_step(input sq_t s, input logic [63:0] bit_v);
    sq_t r;
    r = s;
    if (s.rem >= s.root + bit_v) begin
      r.rem  = s.rem - (s.root + bit_v);
      r.root = (s.root >> 1) + bit_v;
    end else begin
      r.root = s.root >> 1;
    end
    return r;
  endfunction

  // One rotation-mode CORDIC step; shifts round toward minus infinity
  function automatic cd_t cordic_step(input cd_t s, input int k,
                                      input logic signed [35:0] ang);
    cd_t r;
    r = s;
    if (s.z >= 0) begin
      r.x = s.x - (s.y >>> k);
      r.y = s.y + (s.x >>> k);
      r.z = s.z - ang;
    end else begin
      r.x = s.x + (s.y >>> k);
      r.y = s.y - (s.x >>> k);
      r.z = s.z + ang;
    end
    return r;
  endfunction

endpackage

// ===== sv/rvq_isqrt.sv =====
// Two-lane pipelined 64-bit integer square root, one root bit per stage.
// Depends on rvq_pkg (sq_t, isqrt_step).
module rvq_isqrt import rvq_pkg::*; #(
  parameter int SIDE_W = 96
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [63:0]       rad_a,
  input  logic [63:0]       rad_b,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output logic [31:0]       root_a,
  output logic [31:0]       root_b,
  output logic [SIDE_W-1:0] out_side
);

  localparam int STAGES = 32;

  sq_t               a_q [STAGES];
  sq_t               b_q [STAGES];
  logic              v_q [STAGES];
  logic [SIDE_W-1:0] s_q [STAGES];

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    localparam logic [63:0] BIT_V = 64'd1 << (62 - 2 * i);
    if (i == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (rst) v_q[i] <= 1'b0;
        else     v_q[i] <= in_valid;
        a_q[i] <= isqrt_step('{rem: rad_a, root: 64'd0}, BIT_V);
        b_q[i] <= isqrt_step('{rem: rad_b, root: 64'd0}, BIT_V);
        s_q[i] <= in_side;
      end
    end else begin : g_rest
      always_ff @(posedge clk) begin
        if (rst) v_q[i] <= 1'b0;
        else     v_q[i] <= v_q[i-1];
        a_q[i] <= isqrt_step(a_q[i-1], BIT_V);
        b_q[i] <= isqrt_step(b_q[i-1], BIT_V);
        s_q[i] <= s_q[i-1];
      end
    end
  end

  assign out_valid = v_q[STAGES-1];
  assign root_a    = a_q[STAGES-1].root[31:0];
  assign root_b    = b_q[STAGES-1].root[31:0];
  assign out_side  = s_q[STAGES-1];

endmodule

// ===== sv/rvq_div.sv =====
// Pipelined restoring divider, several numerator lanes over one divisor,
// quotient magnitude saturated to 2^30. Depends on rvq_pkg (dv_t, SAT_MAG).
module rvq_div import rvq_pkg::*; #(
  parameter int LANES  = 4,
  parameter int SIDE_W = 36
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [63:0]       num [LANES],
  input  logic [31:0]       den,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output logic [30:0]       quo [LANES],
  output logic [SIDE_W-1:0] out_side
);

  localparam int QBITS  = 31;
  localparam int STAGES = QBITS + 1;

  dv_t               ln_q  [STAGES][LANES];
  logic [31:0]       den_q [STAGES];
  logic              v_q   [STAGES];
  logic [SIDE_W-1:0] s_q   [STAGES];

  // One quotient bit: subtract the shifted divisor where it fits
  function automatic dv_t div_step(input dv_t s, input logic [31:0] dv, input int k);
    dv_t         r;
    logic [63:0] sub;
    r   = s;
    sub = 64'(dv) << k;
    if (!s.over && s.rem >= sub) begin
      r.rem  = s.rem - sub;
      r.q[k] = 1'b1;
    end
    return r;
  endfunction

  // Load: flag quotients that reach 2^31 or more, they saturate anyway
  always_ff @(posedge clk) begin
    if (rst) v_q[0] <= 1'b0;
    else     v_q[0] <= in_valid;
    den_q[0] <= den;
    s_q[0]   <= in_side;
    for (int l = 0; l < LANES; l++) begin
      ln_q[0][l].rem  <= num[l];
      ln_q[0][l].q    <= '0;
      ln_q[0][l].over <= (num[l] >= (64'(den) << QBITS));
    end
  end

  for (genvar j = 0; j < QBITS; j++) begin : g_stage
    localparam int K = QBITS - 1 - j;
    always_ff @(posedge clk) begin
      if (rst) v_q[j+1] <= 1'b0;
      else     v_q[j+1] <= v_q[j];
      den_q[j+1] <= den_q[j];
      s_q[j+1]   <= s_q[j];
      for (int l = 0; l < LANES; l++) begin
        ln_q[j+1][l] <= div_step(ln_q[j][l], den_q[j], K);
      end
    end
  end

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      if (den_q[STAGES-1] == 32'd0)
        quo[l] = '0;
      else if (ln_q[STAGES-1][l].over || ln_q[STAGES-1][l].q > SAT_MAG)
        quo[l] = SAT_MAG;
      else
        quo[l] = ln_q[STAGES-1][l].q;
    end
  end

  assign out_valid = v_q[STAGES-1];
  assign out_side  = s_q[STAGES-1];

endmodule

// ===== sv/rotation_vector_to_quaternion_exp.sv =====
// Top level: rotation vector (Q3.28) to unit quaternion (Q1.30) pipeline.
// Depends on rvq_pkg, rvq_isqrt and rvq_div.
//
// Usage:
//   Drive vec_x/vec_y/vec_z and raise start; the item is taken at each edge
//   with start high and busy low. busy is always low: a new item may enter
//   every cycle.
//   done, registered from the divider's output valid, stays high for one
//   cycle with quat_w/x/y/z and small_branch valid; the result is taken at
//   the edge that ends that cycle.
//   Results come out in input order, one per item, at one item per cycle.
//   The path is a fixed pipeline: square and sum, a 32-stage square root
//   (norm and small-branch denominator side by side), angle reduction,
//   one CORDIC stage per step, three 32x32 products, a 32-stage divider.
//   small_norm_threshold is written with small_norm_threshold_we; write it
//   only while no item is in flight.
//   The receiver cannot stall: every result is shown for exactly one cycle.
//   Reset (rst, synchronous) empties the pipeline and sets the threshold
//   back to 268; items in flight are dropped.
module rotation_vector_to_quaternion_exp import rvq_pkg::*; #(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] vec_x,
  input  logic signed [31:0] vec_y,
  input  logic signed [31:0] vec_z,
  input  logic               small_norm_threshold_we,
  input  logic [30:0]        small_norm_threshold_wdata,
  output logic               done,
  output logic signed [31:0] quat_w,
  output logic signed [31:0] quat_x,
  output logic signed [31:0] quat_y,
  output logic signed [31:0] quat_z,
  output logic               small_branch
);

  localparam int VSIDE_W = 96;
  localparam int DSIDE_W = 36;

  logic [30:0] thr;

  always_ff @(posedge clk) begin
    if (rst)                          thr <= THRESHOLD_RESET;
    else if (small_norm_threshold_we) thr <= small_norm_threshold_wdata;
  end

  assign busy = 1'b0;

  // Input and squares
  logic               s0_valid;
  logic signed [31:0] s0_vx, s0_vy, s0_vz;
  logic [31:0]        mx, my, mz;
  logic               s1_valid;
  logic signed [31:0] s1_vx, s1_vy, s1_vz;
  logic [63:0]        s1_sqx, s1_sqy, s1_sqz;
  logic               s2_valid;
  logic signed [31:0] s2_vx, s2_vy, s2_vz;
  logic [63:0]        s2_sum;

  assign mx = mag32(s0_vx);
  assign my = mag32(s0_vy);
  assign mz = mag32(s0_vz);

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s0_valid <= start & ~busy;
      s1_valid <= s0_valid;
      s2_valid <= s1_valid;
    end
    s0_vx  <= vec_x;
    s0_vy  <= vec_y;
    s0_vz  <= vec_z;
    s1_vx  <= s0_vx;
    s1_vy  <= s0_vy;
    s1_vz  <= s0_vz;
    s1_sqx <= 64'(mx) * 64'(mx);
    s1_sqy <= 64'(my) * 64'(my);
    s1_sqz <= 64'(mz) * 64'(mz);
    s2_vx  <= s1_vx;
    s2_vy  <= s1_vy;
    s2_vz  <= s1_vz;
    s2_sum <= s1_sqx + s1_sqy + s1_sqz;
  end

  // Norm and small-branch denominator
  logic               sq_valid;
  logic [31:0]        sq_n, sq_d;
  logic [VSIDE_W-1:0] sq_side;

  rvq_isqrt #(.SIDE_W(VSIDE_W)) u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s2_valid),
    .rad_a    (s2_sum),
    .rad_b    (s2_sum + ROOT_BIAS),
    .in_side  ({s2_vx, s2_vy, s2_vz}),
    .out_valid(sq_valid),
    .root_a   (sq_n),
    .root_b   (sq_d),
    .out_side (sq_side)
  );

  // Angle reduction: mod 2pi, into [-pi, pi], fold into [-pi/2, pi/2]
  logic               p1_valid, p2_valid;
  cd_t                p1, p2;
  cd_t                p1_next;
  logic signed [33:0] p1_r, p2_r;
  logic signed [33:0] n_s;

  assign n_s = $signed({2'b00, sq_n});

  always_comb begin
    p1_next          = '0;
    p1_next.vx       = sq_side[95:64];
    p1_next.vy       = sq_side[63:32];
    p1_next.vz       = sq_side[31:0];
    p1_next.n        = sq_n;
    p1_next.d        = sq_d;
    p1_next.small_br = ({1'b0, sq_n} < {2'b00, thr});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
      p2_valid <= 1'b0;
    end else begin
      p1_valid <= sq_valid;
      p2_valid <= p1_valid;
    end
    p1 <= p1_next;
    if (sq_n >= FOUR_PI_U)     p1_r <= n_s - (TWO_PI_Q28 <<< 1);
    else if (sq_n >= TWO_PI_U) p1_r <= n_s - TWO_PI_Q28;
    else                       p1_r <= n_s;
    p2 <= p1;
    if (p1_r > PI_Q28) p2_r <= p1_r - TWO_PI_Q28;
    else               p2_r <= p1_r;
  end

  logic c_valid [CORDIC_STEPS+1];
  cd_t  c_q     [CORDIC_STEPS+1];
  cd_t  c0_next;

  always_comb begin
    c0_next   = p2;
    c0_next.x = GAIN_Q30;
    c0_next.y = '0;
    if (p2_r > HALF_PI_Q28) begin
      c0_next.z       = 36'(PI_Q28 - p2_r) <<< 2;
      c0_next.neg_cos = 1'b1;
    end else if (p2_r < -HALF_PI_Q28) begin
      c0_next.z       = 36'(-PI_Q28 - p2_r) <<< 2;
      c0_next.neg_cos = 1'b1;
    end else begin
      c0_next.z       = 36'(p2_r) <<< 2;
      c0_next.neg_cos = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) c_valid[0] <= 1'b0;
    else     c_valid[0] <= p2_valid;
    c_q[0] <= c0_next;
  end

  // CORDIC rotation, one step per stage
  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cordic
    localparam logic signed [35:0] ATAN = atan_q30(k);
    always_ff @(posedge clk) begin
      if (rst) c_valid[k+1] <= 1'b0;
      else     c_valid[k+1] <= c_valid[k];
      c_q[k+1] <= cordic_step(c_q[k], k, ATAN);
    end
  end

  // Products for the large branch, saturated cosine
  cd_t                ce;
  logic signed [35:0] cx;
  logic [31:0]        mye;
  logic               m_valid, m_small;
  logic [63:0]        m_px, m_py, m_pz;
  logic [31:0]        m_mx, m_my, m_mz;
  logic [31:0]        m_n, m_d;
  logic [2:0]         m_sv, m_neg;
  logic signed [31:0] m_wl;

  assign ce  = c_q[CORDIC_STEPS];
  assign cx  = ce.neg_cos ? -ce.x : ce.x;
  assign mye = ce.y[35] ? 32'(-ce.y) : 32'(ce.y);

  always_ff @(posedge clk) begin
    if (rst) m_valid <= 1'b0;
    else     m_valid <= c_valid[CORDIC_STEPS];
    m_small <= ce.small_br;
    m_n     <= ce.n;
    m_d     <= ce.d;
    m_mx    <= mag32(ce.vx);
    m_my    <= mag32(ce.vy);
    m_mz    <= mag32(ce.vz);
    m_px    <= 64'(mye) * 64'(mag32(ce.vx));
    m_py    <= 64'(mye) * 64'(mag32(ce.vy));
    m_pz    <= 64'(mye) * 64'(mag32(ce.vz));
    m_sv    <= {ce.vx[31], ce.vy[31], ce.vz[31]};
    m_neg   <= {ce.y[35] ^ ce.vx[31], ce.y[35] ^ ce.vy[31], ce.y[35] ^ ce.vz[31]};
    if (cx > ONE_Q30)       m_wl <= 32'(ONE_Q30);
    else if (cx < MONE_Q30) m_wl <= 32'(MONE_Q30);
    else                    m_wl <= 32'(cx);
  end

  // Select branch operands and divide
  logic [63:0]        dnum [4];
  logic [31:0]        dden;
  logic [2:0]         dneg;
  logic               q_valid;
  logic [30:0]        qmag [4];
  logic [DSIDE_W-1:0] q_side;
  logic               q_small;
  logic signed [31:0] q_wl;
  logic [2:0]         q_neg;

  always_comb begin
    if (m_small) begin
      dnum[0] = W_NUM;
      dnum[1] = {2'b00, m_mx, 30'd0};
      dnum[2] = {2'b00, m_my, 30'd0};
      dnum[3] = {2'b00, m_mz, 30'd0};
      dden    = m_d;
      dneg    = m_sv;
    end else begin
      dnum[0] = '0;
      dnum[1] = m_px;
      dnum[2] = m_py;
      dnum[3] = m_pz;
      dden    = m_n;
      dneg    = m_neg;
    end
  end

  rvq_div #(.LANES(4), .SIDE_W(DSIDE_W)) u_div (
    .clk      (clk),
    .rst      (rst),
    .in_valid (m_valid),
    .num      (dnum),
    .den      (dden),
    .in_side  ({m_small, m_wl, dneg}),
    .out_valid(q_valid),
    .quo      (qmag),
    .out_side (q_side)
  );

  assign q_small = q_side[35];
  assign q_wl    = q_side[34:3];
  assign q_neg   = q_side[2:0];

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= q_valid;
    small_branch <= q_small;
    quat_w <= q_small ? $signed({1'b0, qmag[0]}) : q_wl;
    quat_x <= q_neg[2] ? -$signed({1'b0, qmag[1]}) : $signed({1'b0, qmag[1]});
    quat_y <= q_neg[1] ? -$signed({1'b0, qmag[2]}) : $signed({1'b0, qmag[2]});
    quat_z <= q_neg[0] ? -$signed({1'b0, qmag[3]}) : $signed({1'b0, qmag[3]});
  end

endmodule

// ===== tb/sv/tb_rotation_vector_to_quaternion_exp.sv =====
`timescale 1ns / 1ps
// Testbench for rotation_vector_to_quaternion_exp: directed table, then random
// rotation vectors over several threshold settings, checked against a local
// predictor of the norm, square root and CORDIC arithmetic. Depends on rvq_pkg.
module tb_rotation_vector_to_quaternion_exp;
  import rvq_pkg::*;

  localparam int SETTLE_CYCLES = 72 + CORDIC_STEPS_DEF + 24;
  localparam int IDLE_LIMIT    = 5000;
  localparam int ITEMS_PER_SET = 270;
  localparam longint SAT_ONE   = 64'sd1073741824;
  localparam longint PI_FX     = 64'sd843314857;
  localparam longint TWO_PI_FX = 64'sd1686629713;

  typedef struct {
    logic signed [31:0] w;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic               sb;
  } quat_t;

  typedef struct {
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] vz;
    bit                 typed;
    quat_t              q;
  } vec_row_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic signed [31:0] vec_x = '0;
  logic signed [31:0] vec_y = '0;
  logic signed [31:0] vec_z = '0;
  logic               thr_we = 1'b0;
  logic [30:0]        thr_wdata = '0;
  logic               done;
  logic signed [31:0] quat_w, quat_x, quat_y, quat_z;
  logic               small_branch;

  logic [30:0] thr_model = THRESHOLD_RESET;
  quat_t       quat_fifo[$];
  int          mismatches = 0;
  int          idle_cycles = 0;

  rotation_vector_to_quaternion_exp dut (
    .clk                        (clk),
    .rst                        (rst),
    .start                      (start),
    .busy                       (busy),
    .vec_x                      (vec_x),
    .vec_y                      (vec_y),
    .vec_z                      (vec_z),
    .small_norm_threshold_we    (thr_we),
    .small_norm_threshold_wdata (thr_wdata),
    .done                       (done),
    .quat_w                     (quat_w),
    .quat_x                     (quat_x),
    .quat_y                     (quat_y),
    .quat_z                     (quat_z),
    .small_branch               (small_branch)
  );

  always #5 clk = ~clk;

  function automatic logic [63:0] int_sqrt(input logic [63:0] val);
    logic [63:0] rem, root, bitv;
    rem = val;
    root = '0;
    bitv = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (rem >= root + bitv) begin
        rem  = rem - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  function automatic longint clip_q30(input longint v);
    if (v > SAT_ONE) return SAT_ONE;
    if (v < -SAT_ONE) return -SAT_ONE;
    return v;
  endfunction

  function automatic longint arctan_step(input int k);
    longint tab[10];
    tab = '{843314857, 497837829, 263043837, 133525159, 67021687,
            33543516, 16775851, 8388437, 4194283, 2097151};
    if (k < 10) return tab[k];
    return longint'(1) << (30 - k);
  endfunction

  function automatic quat_t exp_map(input logic signed [31:0] vx,
                                    input logic signed [31:0] vy,
                                    input logic signed [31:0] vz);
    longint      v[3];
    logic [63:0] m[3];
    logic [63:0] sumsq, n, d, num;
    longint      qi[4];
    longint      r, x, y, z, t, a;
    bit          neg_cos, is_small, neg;
    int          steps;
    quat_t       q;
    v[0] = vx;
    v[1] = vy;
    v[2] = vz;
    sumsq = '0;
    for (int i = 0; i < 3; i++) begin
      m[i] = (v[i] < 0) ? 64'(-v[i]) : 64'(v[i]);
      sumsq += m[i] * m[i];
    end
    n = int_sqrt(sumsq);
    is_small = n < {33'd0, thr_model};
    if (is_small) begin
      d = int_sqrt((64'd1 << 56) + sumsq);
      qi[0] = clip_q30(longint'((64'd1 << 58) / d));
      for (int i = 0; i < 3; i++) begin
        num = m[i] << 30;
        qi[i + 1] = longint'(num / d);
        if (v[i] < 0) qi[i + 1] = -qi[i + 1];
        qi[i + 1] = clip_q30(qi[i + 1]);
      end
    end else begin
      r = longint'(n);
      neg_cos = 1'b0;
      for (int k = 0; k < 4; k++)
        if (r >= TWO_PI_FX) r -= TWO_PI_FX;
      if (r > PI_FX) r -= TWO_PI_FX;
      if (r > PI_FX / 2) begin
        r = PI_FX - r;
        neg_cos = 1'b1;
      end else if (r < -(PI_FX / 2)) begin
        r = -PI_FX - r;
        neg_cos = 1'b1;
      end
      z = r * 4;
      x = 652032874;
      y = 0;
      steps = (CORDIC_STEPS_DEF > 31) ? 31 : CORDIC_STEPS_DEF;
      for (int k = 0; k < steps; k++) begin
        a = arctan_step(k);
        if (z >= 0) begin
          t = x - (y >>> k);
          y = y + (x >>> k);
          z -= a;
        end else begin
          t = x + (y >>> k);
          y = y - (x >>> k);
          z += a;
        end
        x = t;
      end
      qi[0] = clip_q30(neg_cos ? -x : x);
      for (int i = 0; i < 3; i++) begin
        neg = (y < 0) != (v[i] < 0);
        num = ((y < 0) ? 64'(-y) : 64'(y)) * m[i];
        qi[i + 1] = (n == 0) ? 0 : longint'(num / n);
        if (neg) qi[i + 1] = -qi[i + 1];
        qi[i + 1] = clip_q30(qi[i + 1]);
      end
    end
    q.w = qi[0][31:0];
    q.x = qi[1][31:0];
    q.y = qi[2][31:0];
    q.z = qi[3][31:0];
    q.sb = is_small;
    return q;
  endfunction

  // Results: compare with the oldest pending item
  always @(posedge clk) begin
    quat_t e;
    if (!rst && done) begin
      if (quat_fifo.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result w=%0d", quat_w);
      end else begin
        e = quat_fifo.pop_front();
        if (quat_w !== e.w || quat_x !== e.x || quat_y !== e.y || quat_z !== e.z ||
            small_branch !== e.sb) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp %0d %0d %0d %0d sb=%0d got %0d %0d %0d %0d sb=%0d",
                     e.w, e.x, e.y, e.z, e.sb,
                     quat_w, quat_x, quat_y, quat_z, small_branch);
        end
      end
    end
  end

  // Watchdog on cycles with no handshake in either direction
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  int burst_left = 0;

  // Hold the item until taken; gaps come between bursts
  task automatic send_vec(input logic signed [31:0] vx, input logic signed [31:0] vy,
                          input logic signed [31:0] vz, input bit typed, input quat_t tq);
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) != 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    start <= 1'b1;
    vec_x <= vx;
    vec_y <= vy;
    vec_z <= vz;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    quat_fifo.push_back(typed ? tq : exp_map(vx, vy, vz));
  endtask

  task automatic write_threshold(input logic [30:0] val);
    start <= 1'b0;
    while (quat_fifo.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    thr_we <= 1'b1;
    thr_wdata <= val;
    @(posedge clk);
    thr_we <= 1'b0;
    thr_model = val;
  endtask

  function automatic logic signed [31:0] rand_comp(input int mode);
    case (mode)
      0, 1, 2: return $urandom;
      3, 4:    return $signed(32'($urandom_range(0, 800))) - 400;
      5, 6, 7: return $signed($urandom) >>> 1;
      8: begin
        case ($urandom_range(0, 3))
          0:       return 32'sh7fffffff;
          1:       return 32'sh80000000;
          2:       return '0;
          default: return 32'sd1 <<< $urandom_range(0, 31);
        endcase
      end
      default: return $signed($urandom) >>> $urandom_range(2, 30);
    endcase
  endfunction

  initial begin
    vec_row_t   rows[$];
    vec_row_t   row;
    quat_t      none;
    logic [30:0] thr_set[5];
    int          mode;

    none = '{default: '0};
    rows.push_back('{0, 0, 0, 1'b1, '{32'sd1073741824, 0, 0, 0, 1'b1}});
    rows.push_back('{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 1'b0, none});
    rows.push_back('{32'sh80000000, 32'sh80000000, 32'sh80000000, 1'b0, none});
    rows.push_back('{32'sh80000000, 0, 0, 1'b0, none});
    rows.push_back('{32'sh7fffffff, 0, 0, 1'b0, none});
    rows.push_back('{0, 32'sh80000000, 0, 1'b0, none});
    rows.push_back('{0, 0, 32'sh7fffffff, 1'b0, none});
    rows.push_back('{100, 0, 0, 1'b0, none});
    rows.push_back('{-100, 50, -20, 1'b0, none});
    rows.push_back('{267, 0, 0, 1'b0, none});
    rows.push_back('{268, 0, 0, 1'b0, none});
    rows.push_back('{0, -268, 0, 1'b0, none});
    rows.push_back('{32'sd268435456, 0, 0, 1'b0, none});
    rows.push_back('{0, 0, 32'sd421657428, 1'b0, none});
    rows.push_back('{-32'sd843314857, 0, 0, 1'b0, none});
    rows.push_back('{0, 32'sd1073741824, 0, 1'b0, none});
    rows.push_back('{32'sd1342177280, 0, 0, 1'b0, none});
    rows.push_back('{32'sd1686629713, 0, 0, 1'b0, none});
    rows.push_back('{32'sd800000000, -32'sd900000000, 32'sd700000000, 1'b0, none});
    rows.push_back('{-32'sd5000000, 32'sd3000000, -32'sd1, 1'b0, none});
    thr_set = '{THRESHOLD_RESET, 31'd0, 31'h7fffffff, 31'd268435456,
                31'($urandom_range(1, 32'h7ffffffe))};

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[i]) begin
      row = rows[i];
      send_vec(row.vx, row.vy, row.vz, row.typed, row.q);
    end

    foreach (thr_set[s]) begin
      if (s != 0) begin
        write_threshold(thr_set[s]);
        send_vec(0, 0, 0, 1'b0, none);
      end
      for (int i = 0; i < ITEMS_PER_SET; i++) begin
        mode = $urandom_range(0, 9);
        send_vec(rand_comp(mode), rand_comp(mode), rand_comp(mode), 1'b0, none);
      end
    end

    start <= 1'b0;
    while (quat_fifo.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/rvq_pkg.sv
sv/rvq_isqrt.sv
sv/rvq_div.sv
sv/rotation_vector_to_quaternion_exp.sv
tb/sv/tb_rotation_vector_to_quaternion_exp.sv
